### design/pps_pkg.sv
`default_nettype none

package pps_pkg;

    localparam logic [15:0] MAX_PAYLOAD_BYTES = 16'd65535;

    localparam int FEAT_W = 24;
    localparam int RES_W  = 17;
    localparam int NUM_FEATURES = 6;

    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] a;
        logic [31:0] b;
    } arith_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } arith_rsp_t;

endpackage

`default_nettype wire

### design/pps_accum.sv
`default_nettype none

module pps_accum
    import pps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        add_en,
    input  wire logic        clr,
    input  wire logic [7:0]  data_byte,
    output logic      [15:0] count,
    output logic      [23:0] sum,
    output logic      [31:0] sumsq
);

    logic [15:0] count_reg;
    logic [23:0] sum_reg;
    logic [31:0] sumsq_reg;
    logic [15:0] square;

    assign square = data_byte * data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else if (clr)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else if (add_en && (count_reg < MAX_PAYLOAD_BYTES))
        begin
            count_reg <= count_reg + 16'd1;
            sum_reg   <= sum_reg + {16'd0, data_byte};
            sumsq_reg <= sumsq_reg + {16'd0, square};
        end
    end

    assign count = count_reg;
    assign sum   = sum_reg;
    assign sumsq = sumsq_reg;

endmodule

`default_nettype wire

### design/pps_arith.sv
`default_nettype none

module pps_arith
    import pps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire arith_req_t req,
    output arith_rsp_t      rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic        op_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [31:0] bit_reg;
    logic [32:0] x;
    logic [32:0] y;
    logic [33:0] diff;
    logic        ge;

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            x = {1'b0, rem_reg};
            y = {1'b0, q_reg[31:0] | bit_reg};
        end
        else
        begin
            x = {rem_reg, q_reg[63]};
            y = {1'b0, den_reg};
        end
        diff = {1'b0, x} - {1'b0, y};
        ge   = !diff[33];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == OP_SQRT) ? 7'd16 : 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            den_reg <= req.b;
            bit_reg <= 32'h4000_0000;
            if (req.op == OP_SQRT)
            begin
                rem_reg <= req.a[31:0];
                q_reg   <= '0;
            end
            else
            begin
                rem_reg <= '0;
                q_reg   <= req.a;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_SQRT)
            begin
                bit_reg <= bit_reg >> 2;
                if (ge)
                begin
                    rem_reg <= diff[31:0];
                    q_reg   <= {32'd0, (q_reg[31:0] >> 1) + bit_reg};
                end
                else
                begin
                    q_reg <= {32'd0, q_reg[31:0] >> 1};
                end
            end
            else
            begin
                rem_reg <= ge ? diff[31:0] : x[31:0];
                q_reg   <= {q_reg[62:0], ge};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

`default_nettype wire

### design/packet_payload_stats_normalizer.sv
// Channel | Direction | Contents
// s_*     | in        | tdata: payload_byte, src_port, dst_port, proto_number; tlast; tuser
// m_*     | out       | tdata: six normalized features, 17 bits each
//
// A transfer that does not end a packet leaves s_tready high, so the next transfer can follow.
// After the transfer that ends a packet, s_tready stays low until the result is loaded.
// For a packet with bytes, eight divisions and one square root run one after
// another on the shared unit; a packet with no bytes runs only the six normalizing
// divisions, and none when every feature is zero.
// Reset clears the accumulators, the sequencer and the output valid flag.
// A finished result waits in the output register, and the next result stalls until it is taken.
`default_nettype none

module packet_payload_stats_normalizer
    import pps_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // payload_byte, src_port, dst_port, proto_number
    input  wire logic         s_tlast,
    input  wire logic         s_tuser,   // empty_packet
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [103:0] m_tdata    // norm_length, norm_src_port, norm_dst_port,
                                         // norm_protocol, norm_mean, norm_stddev, zero pad
);

    localparam logic [3:0] S_ACC   = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_MUL3  = 4'd3;
    localparam logic [3:0] S_VAR   = 4'd4;
    localparam logic [3:0] S_VARW  = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_SQW   = 4'd7;
    localparam logic [3:0] S_MEAN  = 4'd8;
    localparam logic [3:0] S_MEANW = 4'd9;
    localparam logic [3:0] S_MAX   = 4'd10;
    localparam logic [3:0] S_NORM  = 4'd11;
    localparam logic [3:0] S_NORMW = 4'd12;
    localparam logic [3:0] S_LOAD  = 4'd13;

    logic [3:0]        state_reg;
    logic [2:0]        idx_reg;
    logic [FEAT_W-1:0] mx_reg;
    logic [FEAT_W-1:0] feat_reg [0:NUM_FEATURES-1];
    logic [RES_W-1:0]  res_reg  [0:NUM_FEATURES-1];
    logic [63:0]       prod_reg;
    logic [47:0]       num_reg;
    logic [47:0]       diff_reg;
    logic [31:0]       tmp_reg;
    logic              out_valid_reg;
    logic [103:0]      out_data_reg;

    logic        accept;
    logic        pkt_end;
    logic        load_ok;
    logic        clr;
    logic [15:0] count;
    logic [23:0] sum;
    logic [31:0] sumsq;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    arith_req_t  req;
    arith_rsp_t  rsp;

    assign s_tready = (state_reg == S_ACC);
    assign accept   = s_tvalid && s_tready;
    assign pkt_end  = accept && (s_tuser || s_tlast);
    assign load_ok  = (state_reg == S_LOAD) && (!out_valid_reg || m_tready);
    assign clr      = load_ok;

    pps_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .add_en    (accept && !s_tuser),
        .clr       (clr),
        .data_byte (s_tdata[7:0]),
        .count     (count),
        .sum       (sum),
        .sumsq     (sumsq)
    );

    pps_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mul_a = {16'd0, count};
                mul_b = sumsq;
            end
            S_MUL2:
            begin
                mul_a = {8'd0, sum};
                mul_b = {8'd0, sum};
            end
            default:
            begin
                mul_a = {16'd0, count};
                mul_b = {16'd0, count};
            end
        endcase
    end

    always_comb
    begin
        req.start = 1'b0;
        req.op    = OP_DIV;
        req.a     = '0;
        req.b     = '0;
        case (state_reg)
            S_VAR:
            begin
                req.start = 1'b1;
                req.a     = {diff_reg, 16'd0};
                req.b     = prod_reg[31:0];
            end
            S_SQRT:
            begin
                req.start = 1'b1;
                req.op    = OP_SQRT;
                req.a     = {32'd0, tmp_reg};
            end
            S_MEAN:
            begin
                req.start = 1'b1;
                req.a     = {32'd0, sum, 8'd0};
                req.b     = {16'd0, count};
            end
            S_NORM:
            begin
                req.start = (mx_reg != '0);
                req.a     = {24'd0, feat_reg[idx_reg], 16'd0};
                req.b     = {8'd0, mx_reg};
            end
            default:
            begin
                req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_ACC:
                begin
                    if (pkt_end)
                    begin
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_MUL3;
                S_MUL3:
                begin
                    idx_reg   <= '0;
                    state_reg <= (count == 16'd0) ? S_MAX : S_VAR;
                end
                S_VAR:   state_reg <= S_VARW;
                S_VARW:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:  state_reg <= S_SQW;
                S_SQW:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_MEAN;
                    end
                end
                S_MEAN:  state_reg <= S_MEANW;
                S_MEANW:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_MAX;
                    end
                end
                S_MAX:
                begin
                    if (idx_reg == 3'd5)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_NORM;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
                S_NORM:
                begin
                    if (mx_reg != '0)
                    begin
                        state_reg <= S_NORMW;
                    end
                    else if (idx_reg == 3'd5)
                    begin
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
                S_NORMW:
                begin
                    if (rsp.done)
                    begin
                        if (idx_reg == 3'd5)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_LOAD:
                begin
                    if (load_ok)
                    begin
                        state_reg <= S_ACC;
                    end
                end
                default: state_reg <= S_ACC;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL1 || state_reg == S_MUL2 || state_reg == S_MUL3)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (pkt_end)
        begin
            feat_reg[1] <= {s_tdata[23:8], 8'd0};
            feat_reg[2] <= {s_tdata[39:24], 8'd0};
            feat_reg[3] <= {8'd0, s_tdata[47:40], 8'd0};
        end
        case (state_reg)
            S_MUL1:
            begin
                feat_reg[0] <= {count, 8'd0};
            end
            S_MUL2:
            begin
                num_reg <= prod_reg[47:0];
            end
            S_MUL3:
            begin
                diff_reg <= (num_reg > prod_reg[47:0]) ? (num_reg - prod_reg[47:0]) : 48'd0;
                mx_reg   <= '0;
                if (count == 16'd0)
                begin
                    feat_reg[4] <= '0;
                    feat_reg[5] <= '0;
                end
            end
            S_VARW:
            begin
                if (rsp.done)
                begin
                    tmp_reg <= rsp.q[31:0];
                end
            end
            S_SQW:
            begin
                if (rsp.done)
                begin
                    feat_reg[5] <= {8'd0, rsp.q[15:0]};
                end
            end
            S_MEANW:
            begin
                if (rsp.done)
                begin
                    feat_reg[4] <= {8'd0, rsp.q[15:0]};
                end
            end
            S_MAX:
            begin
                if (feat_reg[idx_reg] > mx_reg)
                begin
                    mx_reg <= feat_reg[idx_reg];
                end
            end
            S_NORM:
            begin
                if (mx_reg == '0)
                begin
                    res_reg[idx_reg] <= '0;
                end
            end
            S_NORMW:
            begin
                if (rsp.done)
                begin
                    res_reg[idx_reg] <= rsp.q[RES_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        if (load_ok)
        begin
            out_data_reg <= {2'b00, res_reg[5], res_reg[4], res_reg[3],
                             res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == S_VARW || state_reg == S_SQW ||
                      state_reg == S_MEANW || state_reg == S_NORMW))
        else $error("divide/sqrt completion outside a wait state");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_ok |=> (m_tvalid && state_reg == S_ACC))
        else $error("loaded result not presented");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[16] && (m_tdata[15:0] != 16'd0)))
        else $error("normalized length above 1.0");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ACC) |-> !s_tready)
        else $error("input accepted during packet-end processing");

endmodule

`default_nettype wire
